### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared constants and types for the I2C bus master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [3:0] P_IDLE       = 4'd0;
    localparam logic [3:0] P_START_REL  = 4'd1;
    localparam logic [3:0] P_START_HIGH = 4'd2;
    localparam logic [3:0] P_START_LOW  = 4'd3;
    localparam logic [3:0] P_BIT_LOW    = 4'd4;
    localparam logic [3:0] P_BIT_HIGH   = 4'd5;
    localparam logic [3:0] P_ACK_LOW    = 4'd6;
    localparam logic [3:0] P_ACK_HIGH   = 4'd7;
    localparam logic [3:0] P_STOP_LOW   = 4'd8;
    localparam logic [3:0] P_STOP_HIGH  = 4'd9;

    localparam logic [2:0] J_WRITE = 3'd0;
    localparam logic [2:0] J_SBYTE = 3'd1;
    localparam logic [2:0] J_MCODE = 3'd2;
    localparam logic [2:0] J_ADDR1 = 3'd3;
    localparam logic [2:0] J_ADDR2 = 3'd4;
    localparam logic [2:0] J_ADDR3 = 3'd5;
    localparam logic [2:0] J_READ  = 3'd6;
    localparam logic [2:0] J_STOP  = 3'd7;

    localparam logic [2:0] REQ_SELECT   = 3'd1;
    localparam logic [2:0] REQ_WRITE    = 3'd2;
    localparam logic [2:0] REQ_READ     = 3'd3;
    localparam logic [2:0] REQ_STOP     = 3'd4;
    localparam logic [2:0] REQ_RESERVED = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ADDR_NAK = 3'd1;
    localparam logic [2:0] ST_DATA_NAK = 3'd2;
    localparam logic [2:0] ST_ARB_LOST = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;

    localparam logic [2:0] REG_HALF  = 3'd0;
    localparam logic [2:0] REG_FS    = 3'd1;
    localparam logic [2:0] REG_HS    = 3'd2;
    localparam logic [2:0] REG_MCODE = 3'd3;
    localparam logic [2:0] REG_SBYTE = 3'd4;

    typedef struct packed {
        logic [15:0] half_period;
        logic [15:0] fs_half_period;
        logic        hs_enable;
        logic [1:0]  hs_code;
        logic        start_byte_enable;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] address;
        logic        read_mode;
        logic [7:0]  write_data;
        logic        ack_after_read;
        logic        sda_in;
        logic        scl_in;
    } t_req;

    typedef struct packed {
        logic       sda_release;
        logic       scl_release;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] read_data;
    } t_res;

endpackage

### rtl/i2cm_regs.sv
// ----------------------------------------------------------------------------
// i2cm_regs
// APB register file holding the bus timing and selection options.
// ----------------------------------------------------------------------------
module i2cm_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output i2cm_pkg::t_cfg o_cfg
);
    i2cm_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period       <= 16'd5;
            r_cfg.fs_half_period    <= 16'd3;
            r_cfg.hs_enable         <= 1'b0;
            r_cfg.hs_code           <= 2'd0;
            r_cfg.start_byte_enable <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                i2cm_pkg::REG_HALF:  r_cfg.half_period       <= pwdata[15:0];
                i2cm_pkg::REG_FS:    r_cfg.fs_half_period    <= pwdata[15:0];
                i2cm_pkg::REG_HS:    r_cfg.hs_enable         <= pwdata[0];
                i2cm_pkg::REG_MCODE: r_cfg.hs_code           <= pwdata[1:0];
                i2cm_pkg::REG_SBYTE: r_cfg.start_byte_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            i2cm_pkg::REG_HALF:  prdata = {16'd0, r_cfg.half_period};
            i2cm_pkg::REG_FS:    prdata = {16'd0, r_cfg.fs_half_period};
            i2cm_pkg::REG_HS:    prdata = {31'd0, r_cfg.hs_enable};
            i2cm_pkg::REG_MCODE: prdata = {30'd0, r_cfg.hs_code};
            i2cm_pkg::REG_SBYTE: prdata = {31'd0, r_cfg.start_byte_enable};
            default:             prdata = 32'd0;
        endcase
    end
endmodule

### rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: advances the line state by one tick per accepted request.
// ----------------------------------------------------------------------------
module i2cm_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  i2cm_pkg::t_req i_req,
    input  i2cm_pkg::t_cfg i_cfg,
    output i2cm_pkg::t_res o_res
);
    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [2:0]  r_job, n_job;
    logic [15:0] r_addr, n_addr;
    logic        r_rd, n_rd;
    logic        r_ack, n_ack;
    logic        r_sda, n_sda;
    logic        r_scl, n_scl;

    logic        done;
    logic [2:0]  st;
    logic [7:0]  rd;
    logic        high, ten;
    logic [15:0] half, tick_inc, a;

    function automatic logic [7:0] job_byte(input logic [2:0] j, input logic [15:0] aw,
                                            input logic rl, input logic [1:0] mc);
        logic [7:0] b;
        begin
            case (j)
                i2cm_pkg::J_SBYTE: b = 8'h01;
                i2cm_pkg::J_MCODE: b = {6'd0, mc};
                i2cm_pkg::J_ADDR1: b = (aw[15:11] == 5'b11110) ? aw[15:8]
                                                               : (aw[7:0] | {7'd0, rl});
                i2cm_pkg::J_ADDR2: b = aw[7:0];
                default:           b = aw[15:8] | 8'h01;
            endcase
            return b;
        end
    endfunction

    always_comb begin
        n_phase = r_phase; n_tick = r_tick; n_bit = r_bit; n_shift = r_shift;
        n_job = r_job; n_addr = r_addr; n_rd = r_rd; n_ack = r_ack;
        n_sda = r_sda; n_scl = r_scl;
        done = 1'b0; st = i2cm_pkg::ST_OK; rd = 8'd0;
        ten = (r_addr[15:11] == 5'b11110);
        half = (r_job == i2cm_pkg::J_MCODE) ? i_cfg.fs_half_period : i_cfg.half_period;
        if (half == 16'd0) half = 16'd1;
        high = (r_phase == i2cm_pkg::P_START_HIGH) || (r_phase == i2cm_pkg::P_BIT_HIGH) ||
               (r_phase == i2cm_pkg::P_ACK_HIGH) || (r_phase == i2cm_pkg::P_STOP_HIGH);
        tick_inc = r_tick + 16'd1;
        a = i_req.address;

        if (r_phase != i2cm_pkg::P_IDLE && !(high && r_tick == 16'd0 && !i_req.scl_in)) begin
            n_tick = tick_inc;
            if ({1'b0, tick_inc} >= {1'b0, half} || tick_inc == 16'd0) begin
                n_tick = 16'd0;
                case (r_phase)
                    i2cm_pkg::P_START_REL: begin
                        n_phase = i2cm_pkg::P_START_HIGH; n_scl = 1'b1;
                    end
                    i2cm_pkg::P_START_HIGH: begin
                        n_phase = i2cm_pkg::P_START_LOW; n_sda = 1'b0;
                    end
                    i2cm_pkg::P_START_LOW: begin
                        n_phase = i2cm_pkg::P_BIT_LOW; n_bit = 4'd7; n_scl = 1'b0;
                        n_sda = (r_job == i2cm_pkg::J_READ) ? 1'b1 : r_shift[7];
                    end
                    i2cm_pkg::P_BIT_LOW: begin
                        n_phase = i2cm_pkg::P_BIT_HIGH; n_scl = 1'b1;
                    end
                    i2cm_pkg::P_BIT_HIGH: begin
                        if (r_job != i2cm_pkg::J_READ && r_shift[r_bit[2:0]] && !i_req.sda_in) begin
                            n_sda = 1'b1; n_scl = 1'b1; n_phase = i2cm_pkg::P_IDLE;
                            done = 1'b1; st = i2cm_pkg::ST_ARB_LOST;
                        end else begin
                            if (r_job == i2cm_pkg::J_READ)
                                n_shift = {r_shift[6:0], i_req.sda_in};
                            n_scl = 1'b0;
                            if (r_bit == 4'd0) begin
                                n_phase = i2cm_pkg::P_ACK_LOW;
                                n_sda = (r_job == i2cm_pkg::J_READ) ? ~r_ack : 1'b1;
                            end else begin
                                n_bit = r_bit - 4'd1;
                                n_phase = i2cm_pkg::P_BIT_LOW;
                                n_sda = (r_job == i2cm_pkg::J_READ) ? 1'b1
                                        : r_shift[n_bit[2:0]];
                            end
                        end
                    end
                    i2cm_pkg::P_ACK_LOW: begin
                        n_phase = i2cm_pkg::P_ACK_HIGH; n_scl = 1'b1;
                    end
                    i2cm_pkg::P_ACK_HIGH: begin
                        if (r_job == i2cm_pkg::J_READ && !r_ack && !i_req.sda_in) begin
                            n_sda = 1'b1; n_scl = 1'b1; n_phase = i2cm_pkg::P_IDLE;
                            done = 1'b1; st = i2cm_pkg::ST_ARB_LOST;
                        end else begin
                            n_scl = 1'b0; n_sda = 1'b1;
                            n_phase = i2cm_pkg::P_IDLE; done = 1'b1;
                            case (r_job)
                                i2cm_pkg::J_READ: rd = r_shift;
                                i2cm_pkg::J_WRITE:
                                    st = i_req.sda_in ? i2cm_pkg::ST_DATA_NAK : i2cm_pkg::ST_OK;
                                i2cm_pkg::J_SBYTE, i2cm_pkg::J_MCODE: begin
                                    done = 1'b0;
                                    n_job = (r_job == i2cm_pkg::J_SBYTE && i_cfg.hs_enable)
                                            ? i2cm_pkg::J_MCODE : i2cm_pkg::J_ADDR1;
                                    n_shift = job_byte(n_job, r_addr, r_rd, i_cfg.hs_code);
                                    n_phase = i2cm_pkg::P_START_REL;
                                end
                                i2cm_pkg::J_ADDR1: begin
                                    if (i_req.sda_in) st = i2cm_pkg::ST_ADDR_NAK;
                                    else if (ten) begin
                                        done = 1'b0;
                                        n_job = i2cm_pkg::J_ADDR2;
                                        n_shift = r_addr[7:0];
                                        n_phase = i2cm_pkg::P_BIT_LOW; n_bit = 4'd7;
                                        n_sda = r_addr[7];
                                    end
                                end
                                i2cm_pkg::J_ADDR2: begin
                                    if (i_req.sda_in) st = i2cm_pkg::ST_ADDR_NAK;
                                    else if (r_rd) begin
                                        done = 1'b0;
                                        n_job = i2cm_pkg::J_ADDR3;
                                        n_shift = r_addr[15:8] | 8'h01;
                                        n_phase = i2cm_pkg::P_START_REL;
                                    end
                                end
                                default:
                                    st = i_req.sda_in ? i2cm_pkg::ST_ADDR_NAK : i2cm_pkg::ST_OK;
                            endcase
                        end
                    end
                    i2cm_pkg::P_STOP_LOW: begin
                        n_phase = i2cm_pkg::P_STOP_HIGH; n_scl = 1'b1;
                    end
                    i2cm_pkg::P_STOP_HIGH: begin
                        n_sda = 1'b1; n_phase = i2cm_pkg::P_IDLE;
                        done = 1'b1;
                    end
                    default: n_phase = i2cm_pkg::P_IDLE;
                endcase
            end
        end

        if (i_req.req_type inside {[i2cm_pkg::REQ_SELECT:i2cm_pkg::REQ_STOP]}) begin
            if (n_phase != i2cm_pkg::P_IDLE) begin
                st = i2cm_pkg::ST_REJECTED;
            end else begin
                n_tick = 16'd0;
                case (i_req.req_type)
                    i2cm_pkg::REQ_SELECT: begin
                        if (a[15:11] == 5'b11110) a = {a[15:9], 1'b0, a[8:1]};
                        else if (a[7:0] == 8'd0) a = {8'd0, a[15:8]};
                        n_addr = a; n_rd = i_req.read_mode;
                        n_job = i_cfg.start_byte_enable ? i2cm_pkg::J_SBYTE
                              : i_cfg.hs_enable ? i2cm_pkg::J_MCODE : i2cm_pkg::J_ADDR1;
                        n_shift = job_byte(n_job, a, i_req.read_mode, i_cfg.hs_code);
                        n_phase = i2cm_pkg::P_START_REL; n_sda = 1'b1;
                    end
                    i2cm_pkg::REQ_WRITE: begin
                        n_job = i2cm_pkg::J_WRITE; n_shift = i_req.write_data;
                        n_phase = i2cm_pkg::P_BIT_LOW; n_bit = 4'd7; n_scl = 1'b0;
                        n_sda = i_req.write_data[7];
                    end
                    i2cm_pkg::REQ_READ: begin
                        n_job = i2cm_pkg::J_READ; n_ack = i_req.ack_after_read;
                        n_phase = i2cm_pkg::P_BIT_LOW; n_bit = 4'd7; n_scl = 1'b0;
                        n_sda = 1'b1;
                    end
                    default: begin
                        n_job = i2cm_pkg::J_STOP; n_phase = i2cm_pkg::P_STOP_LOW;
                        n_sda = 1'b0;
                    end
                endcase
            end
        end
    end

    // State register; the state is held while a result waits downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cm_pkg::P_IDLE; r_tick <= 16'd0; r_bit <= 4'd0;
            r_shift <= 8'd0; r_job <= i2cm_pkg::J_WRITE; r_addr <= 16'd0; r_rd <= 1'b0;
            r_ack <= 1'b0; r_sda <= 1'b1; r_scl <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase; r_tick <= n_tick; r_bit <= n_bit;
            r_shift <= n_shift; r_job <= n_job; r_addr <= n_addr; r_rd <= n_rd;
            r_ack <= n_ack; r_sda <= n_sda; r_scl <= n_scl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            o_res.sda_release <= n_sda;
            o_res.scl_release <= n_scl;
            o_res.busy_res    <= (n_phase != i2cm_pkg::P_IDLE);
            o_res.done_res    <= done;
            o_res.status      <= st;
            o_res.read_data   <= rd;
        end
    end
endmodule

### rtl/i2c_bus_master.sv
// ----------------------------------------------------------------------------
// i2c_bus_master
// I2C master sequencer stepped once per tick, with APB configuration.
//
// Channel  Direction  Handshake             Contents
// in       input      i_in_valid/o_in_stall  request and sampled lines
// out      output     o_out_valid/i_out_stall one tick result
//
// One tick is taken per cycle unless stalled; the result is registered
// and appears in the cycle after acceptance. The single result register
// holds one tick. The input is stalled only while that register is full
// and stalled. Synchronous reset releases both sequencer line states.
// ----------------------------------------------------------------------------
module i2c_bus_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_address,
    input  logic        i_read_mode,
    input  logic [7:0]  i_write_data,
    input  logic        i_ack_after_read,
    input  logic        i_sda_in,
    input  logic        i_scl_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_sda_release,
    output logic        o_scl_release,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [7:0]  o_read_data
);
    i2cm_pkg::t_cfg cfg;
    i2cm_pkg::t_req req;
    i2cm_pkg::t_res res;
    logic           r_valid;
    logic           step;

    assign o_in_stall = r_valid && i_out_stall;
    assign step       = i_in_valid && !o_in_stall;

    assign req = '{req_type: i_req_type, address: i_address, read_mode: i_read_mode,
                   write_data: i_write_data, ack_after_read: i_ack_after_read,
                   sda_in: i_sda_in, scl_in: i_scl_in};

    i2cm_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg)
    );

    i2cm_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_req(req),
        .i_cfg(cfg), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_sda_release = res.sda_release;
    assign o_scl_release = res.scl_release;
    assign o_busy_res    = res.busy_res;
    assign o_done_res    = res.done_res;
    assign o_status      = res.status;
    assign o_read_data   = res.read_data;
endmodule

### rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port level checks for the I2C bus master.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_done_res,
    input logic       o_busy_res,
    input logic [2:0] o_status,
    input logic [7:0] o_read_data,
    input logic       o_in_stall
);
    // A held result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_read_data) && $stable(o_status))
        else $error("stalled result changed");

    // The input stalls only when a result is held.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without cause");

    // A rejected command never coincides with a finished one and shows busy.
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == i2cm_pkg::ST_REJECTED |-> !o_done_res && o_busy_res)
        else $error("bad reject report");

    // Read data is only shown on completion.
    a_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> o_read_data == 8'd0)
        else $error("read data without done");
endmodule

bind i2c_bus_master i2cm_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_done_res(o_done_res), .o_busy_res(o_busy_res),
    .o_status(o_status), .o_read_data(o_read_data), .o_in_stall(o_in_stall)
);
